@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; included by longest_prefix_route_lookup.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/lprl_pkg.sv @@
// Types and constants for the longest prefix route lookup.
// No dependencies; used by lprl_cell and longest_prefix_route_lookup.
package lprl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PORT_COUNT_DEF  = 4;

    localparam int ADDR_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int PORT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] entry_slot;
        logic [ADDR_W-1:0] entry_prefix;
        logic [ADDR_W-1:0] entry_netmask;
        logic [ADDR_W-1:0] entry_next_hop;
        logic [PORT_W-1:0] entry_port;
        logic [ADDR_W-1:0] lookup_addr;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] gateway_addr;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] best_mask;
    } t_out_word;

    // lookup in flight through the cell row
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] best;
        logic [ADDR_W-1:0] gw;
        logic [PORT_W-1:0] port;
        logic              found;
    } t_token;

    // table write broadcast to all cells
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] netmask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } t_entry_wr;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

@@ rtl/lprl_cell.sv @@
// One route table entry plus one stage of the lookup row.
// Depends on lprl_pkg.
module lprl_cell import lprl_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [COUNT_W-1:0] i_count,
    input  t_entry_wr          i_wr,
    input  t_token             i_tok,
    output t_token             o_tok
);

    logic [ADDR_W-1:0] r_prefix;
    logic [ADDR_W-1:0] r_netmask;
    logic [ADDR_W-1:0] r_gateway;
    logic [PORT_W-1:0] r_port;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_active;
    logic              w_take;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && (32'(i_wr.slot) == CELL_IDX)) begin
            r_prefix  <= i_wr.prefix;
            r_netmask <= i_wr.netmask;
            r_gateway <= i_wr.gateway;
            r_port    <= i_wr.port;
        end
    end

    // entries at or past the configured count are skipped
    assign w_active = (32'(i_count) > CELL_IDX);
    assign w_take   = i_tok.valid && w_active
                   && ((i_tok.addr & r_netmask) == (r_prefix & r_netmask))
                   && ((r_netmask & i_tok.best) == i_tok.best);

    always_comb begin
        n_tok = i_tok;
        if (w_take) begin
            n_tok.best  = r_netmask;
            n_tok.gw    = r_gateway;
            n_tok.port  = r_port;
            n_tok.found = 1'b1;
        end
    end

    // only the valid bit is reset; the payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= n_tok.valid;
        end
        if (i_adv) begin
            r_tok.addr  <= n_tok.addr;
            r_tok.best  <= n_tok.best;
            r_tok.gw    <= n_tok.gw;
            r_tok.port  <= n_tok.port;
            r_tok.found <= n_tok.found;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/longest_prefix_route_lookup.sv @@
// Top level of the longest prefix route lookup: control, config and the row of cells.
// Depends on lprl_pkg, lprl_cell and assert_macros.svh.
//
//   channel  | signals                           | moves
//   ---------+-----------------------------------+---------------------------
//   in       | i_in_valid, o_in_ready, i_in_word | table write or lookup word
//   out      | o_out_valid, i_out_ready, o_out_word | one word per lookup
//   cfg      | i_cfg_we, i_cfg_wdata             | entries_in_use
//
// A write word is taken while idle. A lookup walks the row of TABLE_DEPTH cells, one
// cell per cycle while the row is not stalled, then lands in the output register.
// No new word is taken until that lookup has reached the output register.
// Synchronous active-low reset clears control only; table contents stay undefined
// until written. A finished word facing a full output register that is not taken freezes the row.
`include "assert_macros.svh"

module longest_prefix_route_lookup import lprl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PORT_COUNT  = PORT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word
);

    t_state             r_state;
    t_state             n_state;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_out_word          r_out_word;
    logic               w_in_ready;
    logic               w_accept;
    logic               w_adv;
    t_entry_wr          w_wr;
    t_token             w_tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_tok_vld;
    t_token             w_tail;

    assign w_accept = i_in_valid && w_in_ready;
    assign w_tail   = w_tok[TABLE_DEPTH];
    // row stalls only when a finished word cannot move into the output register
    assign w_adv    = !(w_tail.valid && r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_wr.we      = w_accept && (i_in_word.func == FUNC_WRITE);
        w_wr.slot    = i_in_word.entry_slot;
        w_wr.prefix  = i_in_word.entry_prefix;
        w_wr.netmask = i_in_word.entry_netmask;
        w_wr.gateway = i_in_word.entry_next_hop;
        if (32'(i_in_word.entry_port) >= 32'(PORT_COUNT)) begin
            w_wr.port = PORT_W'(PORT_COUNT - 1);
        end else begin
            w_wr.port = i_in_word.entry_port;
        end
    end

    always_comb begin
        w_tok[0].valid = w_accept && (i_in_word.func == FUNC_LOOKUP);
        w_tok[0].addr  = i_in_word.lookup_addr;
        w_tok[0].best  = '0;
        w_tok[0].gw    = '0;
        w_tok[0].port  = '0;
        w_tok[0].found = 1'b0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        lprl_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_count (r_count),
            .i_wr    (w_wr),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_tok_vld[g] = w_tok[g+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid && (i_in_word.func == FUNC_LOOKUP)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tail.valid && w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tail.valid && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // miss leaves best, gateway and port at their zero start values
    always_ff @(posedge i_clk) begin
        if (w_tail.valid && w_adv) begin
            r_out_word.hit          <= w_tail.found;
            r_out_word.gateway_addr <= w_tail.gw;
            r_out_word.out_port     <= w_tail.port;
            r_out_word.best_mask    <= w_tail.best;
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_NEXT(a_lookup_starts_scan, i_clk, i_rst_n, w_tok[0].valid, r_state == ST_SCAN)
    `ASSERT_SAME(a_tail_only_in_scan, i_clk, i_rst_n, w_tail.valid, r_state == ST_SCAN)
    `ASSERT_SAME(a_one_lookup_in_row, i_clk, i_rst_n, 1'b1, $onehot0(w_tok_vld))
    `ASSERT_NEXT(a_stall_holds_tail, i_clk, i_rst_n, !w_adv, w_tail.valid)

endmodule
